### rtl/core/kht_pkg.sv
// kht_pkg: shared types and codes for the key hold tracker.
// Used by kht_ctrl, kht_dp and key_hold_tracker; no dependencies.
package kht_pkg;

    localparam int MODE_COUNT = 5;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [2:0] MODE_OVER       = 3'd0;
    localparam logic [2:0] MODE_AT_LEAST   = 3'd1;
    localparam logic [2:0] MODE_EQUAL_ONCE = 3'd2;
    localparam logic [2:0] MODE_AT_MOST    = 3'd3;
    localparam logic [2:0] MODE_LESS_THAN  = 3'd4;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    // Controller to datapath
    typedef struct packed {
        logic clr_en;
        logic load;
        logic rd_en;
        logic commit;
    } kht_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
    } kht_sts_t;

endpackage

### rtl/core/kht_ctrl.sv
// kht_ctrl: sequencing FSM for the key hold tracker (clear sweep, read, update).
// Depends on kht_pkg.
module kht_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output kht_pkg::kht_cmd_t cmd,
    input  kht_pkg::kht_sts_t sts
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        cmd        = '0;
        cmd.clr_en = (state_reg == ST_CLEAR);
        cmd.load   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.rd_en  = (state_reg == ST_READ);
        cmd.commit = (state_reg == ST_EXEC) && out_free;
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR: begin
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/core/kht_dp.sv
// kht_dp: key table memory, item registers, counter/latch update and result register.
// Depends on kht_pkg; driven by kht_ctrl.
module kht_dp #(
    parameter int KEY_COUNT   = 256,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [kht_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,
    output logic [kht_pkg::M_TDATA_W-1:0]     m_tdata,
    input  kht_pkg::kht_cmd_t                 cmd,
    output kht_pkg::kht_sts_t                 sts
);

    localparam int ADDR_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int EW     = COUNT_WIDTH + kht_pkg::MODE_COUNT;
    localparam int XW     = 33;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
    localparam logic [XW-1:0]          SHOW_MAX = XW'(32767);

    logic [EW-1:0]     mem_reg [KEY_COUNT];
    logic [EW-1:0]     entry_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic        cmd_reg;
    logic [7:0]  key_reg;
    logic        pressed_reg;
    logic [14:0] thr_reg;
    logic [2:0]  mode_reg;
    logic [kht_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [ADDR_W-1:0]               addr;
    logic                            in_range;
    logic [COUNT_WIDTH-1:0]          cnt, cnt_new, rc;
    logic [kht_pkg::MODE_COUNT-1:0]  lat, lat_new, bit_mask;
    logic                            cnt_pos, latched, match, k_zero;
    logic [XW-1:0]                   k_ext, thr_ext, rc_ext;
    logic [15:0]                     shown;
    logic                            held, jp, jr;

    assign addr     = ADDR_W'(key_reg);
    assign in_range = (32'(key_reg) < 32'(KEY_COUNT));
    assign sts.clr_last = (clr_addr_reg == ADDR_W'(KEY_COUNT - 1));
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        cnt      = entry_reg[COUNT_WIDTH-1:0];
        lat      = entry_reg[EW-1:COUNT_WIDTH];
        cnt_pos  = !cnt[COUNT_WIDTH-1] && (cnt != '0);
        k_zero   = !cnt_pos;
        k_ext    = cnt[COUNT_WIDTH-1] ? '0 : XW'(cnt);
        thr_ext  = XW'(thr_reg);
        bit_mask = {{(kht_pkg::MODE_COUNT-1){1'b0}}, 1'b1} << mode_reg;
        latched  = |(lat & bit_mask);
        lat_new  = lat;
        match    = 1'b0;
        cnt_new  = cnt;

        if (cmd_reg == kht_pkg::CMD_SAMPLE) begin
            if (pressed_reg) begin
                cnt_new = (cnt != CNT_MAX) ? cnt + CNT_ONE : cnt;
            end else begin
                cnt_new = cnt_pos ? '1 : '0;
            end
        end else if (k_zero) begin
            lat_new = lat & ~bit_mask;
        end else begin
            case (mode_reg)
                kht_pkg::MODE_OVER: begin
                    if (latched || (k_ext > thr_ext)) begin
                        match   = 1'b1;
                        lat_new = lat | bit_mask;
                    end
                end
                kht_pkg::MODE_AT_LEAST: begin
                    if (latched || (k_ext >= thr_ext)) begin
                        match   = 1'b1;
                        lat_new = lat | bit_mask;
                    end
                end
                kht_pkg::MODE_EQUAL_ONCE: begin
                    if (!latched && (k_ext == thr_ext)) begin
                        match   = 1'b1;
                        lat_new = lat | bit_mask;
                    end
                end
                kht_pkg::MODE_AT_MOST: begin
                    if (!latched) begin
                        if (k_ext <= thr_ext) begin
                            match = 1'b1;
                        end else begin
                            lat_new = lat | bit_mask;
                        end
                    end
                end
                kht_pkg::MODE_LESS_THAN: begin
                    if (!latched) begin
                        if (k_ext < thr_ext) begin
                            match = 1'b1;
                        end else begin
                            lat_new = lat | bit_mask;
                        end
                    end
                end
                default: begin
                    match = 1'b0;
                end
            endcase
        end

        if (!in_range) begin
            rc    = '0;
            match = 1'b0;
        end else begin
            rc = cnt_new;
        end

        rc_ext = {{(XW-COUNT_WIDTH){rc[COUNT_WIDTH-1]}}, rc};
        if (!rc[COUNT_WIDTH-1] && (rc_ext > SHOW_MAX)) begin
            shown = 16'h7FFF;
        end else begin
            shown = rc_ext[15:0];
        end
        held = !rc[COUNT_WIDTH-1] && (rc != '0);
        jp   = (rc == CNT_ONE);
        jr   = (rc == '1);
    end

    // Item capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg     <= s_tuser;
            key_reg     <= s_tdata[7:0];
            pressed_reg <= s_tdata[8];
            thr_reg     <= s_tdata[23:9];
            mode_reg    <= s_tdata[26:24];
        end
    end

    // Key table
    always_ff @(posedge aclk) begin
        if (cmd.clr_en) begin
            mem_reg[clr_addr_reg] <= '0;
        end else if (cmd.commit && in_range) begin
            mem_reg[addr] <= {lat_new, cnt_new};
        end
        if (cmd.rd_en) begin
            entry_reg <= mem_reg[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_en && !sts.clr_last) begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tdata_reg <= {3'b000, match, !held, jr, jp, held, shown};
        end
    end

endmodule

### rtl/core/key_hold_tracker.sv
// key_hold_tracker: top level of the per-key hold time tracker.
// Depends on kht_pkg, kht_ctrl and kht_dp.
//
// Each input transfer is either a sample (tuser = 0) that advances one key's
// hold counter by one frame while pressed or marks it released, or a query
// (tuser = 1) that compares that key's hold time with a frame threshold in
// one of five modes; every input transfer yields exactly one result transfer.
// Each item goes through capture, table read, then update and write-back on
// the single-port key table that holds the counter and mode latches of every
// key. The next item is accepted while a result waits on the output. After
// reset the table is cleared one entry per cycle, with s_tready low meanwhile.
module key_hold_tracker #(
    parameter int KEY_COUNT   = 256,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // [7:0] key_index, [8] pressed, [23:9] threshold_frames,
    // [26:24] compare_mode, [31:27] zero
    input  logic [kht_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] command
    input  logic                          s_tuser,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [15:0] hold_count, [16] is_held, [17] just_pressed, [18] just_released,
    // [19] is_released, [20] time_match, [23:21] zero
    output logic [kht_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready
);

    kht_pkg::kht_cmd_t cmd;
    kht_pkg::kht_sts_t sts;

    kht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    kht_dp #(
        .KEY_COUNT   (KEY_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule
